[rtl/whr_pkg.sv]
// Shared types and constants for the weighted temperature histogram.
// No dependencies; used by the front, back and top modules of the block.
`default_nettype none

package whr_pkg;

    // Default table geometry
    localparam int DEF_NUM_BINS  = 64;
    localparam int DEF_NUM_SLOTS = 32;

    // Field widths
    localparam int SLOT_IN_W = 5;
    localparam int TEMP_W    = 16;
    localparam int VOL_W     = 32;
    localparam int DENS_W    = 24;
    localparam int FRAC_W    = 16;
    localparam int RBIN_W    = 6;
    localparam int BIN_OUT_W = 6;
    localparam int SUM_W     = 63;
    localparam int PROD_W    = VOL_W + DENS_W;      // volume times density
    localparam int MASS_W    = 40;                  // scaled mass increment

    // Stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 136;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;

    // Request kinds
    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_MIN  = 1'b0,
        REG_BIN_WIDTH = 1'b1
    } cfg_reg_t;

    localparam logic [TEMP_W-1:0] TEMP_MIN_RST  = 16'd20800;
    localparam logic [TEMP_W-1:0] BIN_WIDTH_RST = 16'd160;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

`default_nettype wire

[rtl/whr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; instantiated for both histogram tables.
`default_nettype none

module whr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/whr_fifo.sv]
// Small register queue between the front and back of the histogram.
// Depends on nothing; DEPTH must be a power of two, two or more.
`default_nettype none

module whr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg;
    logic [PTR_W:0]   rd_ptr_reg;

    // Pointers carry one wrap bit to tell full from empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg[PTR_W-1:0]] <= push_data;
        end
    end

    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign full     = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                      (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign pop_data = mem_reg[rd_ptr_reg[PTR_W-1:0]];

    // Users must never overrun or underrun the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

[rtl/whr_front.sv]
// Front of the histogram: config registers, request capture, bin divider
// and mass product. Depends on whr_pkg; feeds commands into whr_fifo.
`default_nettype none

module whr_front #(
    parameter int NUM_BINS  = whr_pkg::DEF_NUM_BINS,
    parameter int NUM_SLOTS = whr_pkg::DEF_NUM_SLOTS,
    parameter int CMD_W     = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration writes
    input  wire logic                             cfg_we,
    input  wire logic [whr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [whr_pkg::CFG_DATA_W-1:0]   cfg_data,
    // incoming requests
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire whr_pkg::op_t                     in_op,
    input  wire logic [whr_pkg::SLOT_IN_W-1:0]    in_slot,
    input  wire logic [whr_pkg::TEMP_W-1:0]       in_temp,
    input  wire logic [whr_pkg::VOL_W-1:0]        in_vol,
    input  wire logic [whr_pkg::DENS_W-1:0]       in_dens,
    input  wire logic [whr_pkg::FRAC_W-1:0]       in_frac,
    input  wire logic [whr_pkg::RBIN_W-1:0]       in_rbin,
    // back status and queue
    input  wire logic                             clearing,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output logic      [CMD_W-1:0]                 q_data
);

    localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ADDR_W    = $clog2(NUM_SLOTS * NUM_BINS);
    localparam int WORK_CYC  = (BIN_W > 2) ? BIN_W : 2;
    localparam int CNT_W     = $clog2(WORK_CYC + 1);
    localparam int DIV_START = WORK_CYC - BIN_W;
    localparam int DSR_W     = whr_pkg::TEMP_W + BIN_W;
    localparam int SLOT_TBL  = 2 ** whr_pkg::SLOT_IN_W;
    localparam int LO_W      = 32;
    localparam int LOP_W     = LO_W + whr_pkg::FRAC_W;

    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);

    typedef enum logic [1:0] {
        F_IDLE,
        F_WORK,
        F_PUSH
    } front_state_t;

    front_state_t state_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [whr_pkg::TEMP_W-1:0] temp_min_reg;
    logic [whr_pkg::TEMP_W-1:0] bin_width_reg;

    // captured request
    whr_pkg::op_t               op_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [whr_pkg::VOL_W-1:0]  vol_reg;
    logic [whr_pkg::DENS_W-1:0] dens_reg;
    logic [whr_pkg::FRAC_W-1:0] frac_reg;
    logic [BIN_W-1:0]           rbin_reg;
    logic                       under_reg;

    // divider
    logic [whr_pkg::TEMP_W-1:0] rem_reg;
    logic [DSR_W-1:0]           dsr_reg;
    logic [BIN_W-1:0]           quo_reg;

    // mass product
    logic [whr_pkg::PROD_W-1:0] prod_reg;
    logic [whr_pkg::MASS_W-1:0] phi_reg;
    logic [whr_pkg::FRAC_W-1:0] plo_reg;
    logic [LOP_W-1:0]           lo_prod;

    logic [SLOT_W-1:0]          slot_tbl [SLOT_TBL];
    logic                       accept;
    logic                       push_ok;
    logic                       div_step;
    logic                       div_ge;
    logic [whr_pkg::TEMP_W-1:0] w_eff;
    logic [BIN_W-1:0]           rbin_clamp;
    logic [BIN_W-1:0]           bin_acc;
    logic [BIN_W-1:0]           bin_sel;
    logic [ADDR_W-1:0]          addr;
    logic [whr_pkg::MASS_W-1:0] mass;

    // slot wraps modulo the number of slots: small constant table
    for (genvar gi = 0; gi < SLOT_TBL; gi++)
    begin : g_slot_tbl
        localparam int SLOT_MOD = gi % NUM_SLOTS;
        assign slot_tbl[gi] = SLOT_W'(SLOT_MOD);
    end

    // Handshake: take a new request when idle or while the last one leaves, never while clearing
    assign push_ok  = (state_reg == F_PUSH) && !q_full;
    assign in_ready = !clearing && ((state_reg == F_IDLE) || push_ok);
    assign accept   = in_valid && in_ready;
    assign q_push   = push_ok;

    assign w_eff      = (bin_width_reg == '0) ? whr_pkg::TEMP_W'(1) : bin_width_reg;
    assign rbin_clamp = (32'(in_rbin) > 32'(NUM_BINS - 1)) ? BIN_LAST : BIN_W'(in_rbin);

    // Restoring divider, one quotient bit per cycle at the start of the work state
    assign div_step = (state_reg == F_WORK) && (cnt_reg > CNT_W'(DIV_START));
    assign div_ge   = DSR_W'(rem_reg) >= dsr_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_min_reg  <= whr_pkg::TEMP_MIN_RST;
            bin_width_reg <= whr_pkg::BIN_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            case (whr_pkg::cfg_reg_t'(cfg_index))
                whr_pkg::REG_TEMP_MIN:  temp_min_reg  <= cfg_data;
                whr_pkg::REG_BIN_WIDTH: bin_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            state_reg <= (in_op == whr_pkg::OP_ACCUM) ? F_WORK : F_PUSH;
            cnt_reg   <= CNT_W'(WORK_CYC);
        end
        else
        begin
            case (state_reg)
                F_WORK:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (push_ok)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Request capture and divider datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_op;
            slot_reg  <= slot_tbl[in_slot];
            vol_reg   <= in_vol;
            dens_reg  <= in_dens;
            frac_reg  <= in_frac;
            rbin_reg  <= rbin_clamp;
            under_reg <= in_temp < temp_min_reg;
            rem_reg   <= in_temp - temp_min_reg;
            dsr_reg   <= DSR_W'(w_eff) << (BIN_W - 1);
            quo_reg   <= '0;
        end
        else if (div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dsr_reg[whr_pkg::TEMP_W-1:0];
            end
            dsr_reg <= dsr_reg >> 1;
            quo_reg <= BIN_W'({quo_reg, div_ge});
        end
    end

    // Mass product: volume*density, then split against the fraction
    assign lo_prod = LOP_W'(prod_reg[LO_W-1:0]) * LOP_W'(frac_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= whr_pkg::PROD_W'(vol_reg) * whr_pkg::PROD_W'(dens_reg);
        phi_reg  <= whr_pkg::MASS_W'(prod_reg[whr_pkg::PROD_W-1:LO_W]) *
                    whr_pkg::MASS_W'(frac_reg);
        plo_reg  <= lo_prod[LOP_W-1:LO_W];
    end

    // Command assembly: clamp the bin, form the table address
    assign bin_acc = under_reg ? '0 : ((quo_reg > BIN_LAST) ? BIN_LAST : quo_reg);
    assign bin_sel = (op_reg == whr_pkg::OP_READ) ? rbin_reg : bin_acc;
    assign addr    = ADDR_W'(slot_reg) * ADDR_W'(NUM_BINS) + ADDR_W'(bin_sel);
    assign mass    = phi_reg + whr_pkg::MASS_W'(plo_reg);
    assign q_data  = {op_reg, addr, whr_pkg::BIN_OUT_W'(bin_sel), vol_reg, mass};

    a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> bin_sel <= BIN_LAST)
        else $error("bin past the last bin leaves the front");

endmodule

`default_nettype wire

[rtl/whr_back.sv]
// Back of the histogram: clearing pass, table read-modify-write with
// saturation, and the result register. Depends on whr_pkg and whr_ram.
`default_nettype none

module whr_back #(
    parameter int NUM_BINS  = whr_pkg::DEF_NUM_BINS,
    parameter int NUM_SLOTS = whr_pkg::DEF_NUM_SLOTS,
    parameter int CMD_W     = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // queue
    input  wire logic                             q_empty,
    input  wire logic [CMD_W-1:0]                 q_data,
    output logic                                  q_pop,
    output logic                                  clearing,
    // results
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [whr_pkg::BIN_OUT_W-1:0]    m_bin,
    output logic      [whr_pkg::SUM_W-1:0]        m_vol_sum,
    output logic      [whr_pkg::SUM_W-1:0]        m_mass_sum,
    output logic                                  m_sat
);

    localparam int DEPTH  = NUM_SLOTS * NUM_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int VOL_LO = whr_pkg::MASS_W;
    localparam int BIN_LO = VOL_LO + whr_pkg::VOL_W;
    localparam int ADR_LO = BIN_LO + whr_pkg::BIN_OUT_W;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_UPD
    } back_state_t;

    back_state_t state_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    whr_pkg::op_t                  op_reg;
    logic [ADDR_W-1:0]             addr_reg;
    logic [whr_pkg::BIN_OUT_W-1:0] bin_reg;
    logic [whr_pkg::VOL_W-1:0]     vol_reg;
    logic [whr_pkg::MASS_W-1:0]    mass_reg;

    logic                          m_valid_reg;
    logic [whr_pkg::BIN_OUT_W-1:0] m_bin_reg;
    logic [whr_pkg::SUM_W-1:0]     m_vol_reg;
    logic [whr_pkg::SUM_W-1:0]     m_mass_reg;
    logic                          m_sat_reg;

    whr_pkg::op_t                  cmd_op;
    logic [ADDR_W-1:0]             cmd_addr;

    logic                          out_free;
    logic                          upd_done;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [whr_pkg::SUM_W-1:0]     rd_vol;
    logic [whr_pkg::SUM_W-1:0]     rd_mass;
    logic [whr_pkg::SUM_W-1:0]     res_vol;
    logic [whr_pkg::SUM_W-1:0]     res_mass;
    logic [whr_pkg::SUM_W-1:0]     wr_vol;
    logic [whr_pkg::SUM_W-1:0]     wr_mass;

    // Add with saturation at the largest sum
    function automatic logic [whr_pkg::SUM_W-1:0] sat_add(
        input logic [whr_pkg::SUM_W-1:0]  a,
        input logic [whr_pkg::MASS_W-1:0] b
    );
        logic [whr_pkg::SUM_W:0] sum;
        sum = {1'b0, a} + (whr_pkg::SUM_W + 1)'(b);
        return sum[whr_pkg::SUM_W] ? whr_pkg::SUM_MAX : sum[whr_pkg::SUM_W-1:0];
    endfunction

    // Queue head fields
    assign cmd_op   = whr_pkg::op_t'(q_data[CMD_W-1]);
    assign cmd_addr = q_data[ADR_LO +: ADDR_W];

    assign clearing = (state_reg == B_CLEAR);
    assign out_free = !m_valid_reg || m_ready;
    assign upd_done = (state_reg == B_UPD) && out_free;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    // New sums from the registered table read
    assign res_vol  = (op_reg == whr_pkg::OP_ACCUM) ?
                      sat_add(rd_vol, whr_pkg::MASS_W'(vol_reg)) : rd_vol;
    assign res_mass = (op_reg == whr_pkg::OP_ACCUM) ? sat_add(rd_mass, mass_reg) : rd_mass;

    // Write port: zeros during the clearing pass, updated sums otherwise
    assign wr_en   = clearing || (upd_done && (op_reg == whr_pkg::OP_ACCUM));
    assign wr_addr = clearing ? clr_cnt_reg : addr_reg;
    assign wr_vol  = clearing ? '0 : res_vol;
    assign wr_mass = clearing ? '0 : res_mass;

    whr_ram #(
        .WIDTH (whr_pkg::SUM_W),
        .DEPTH (DEPTH)
    ) u_vol_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_vol),
        .rd_en   (q_pop),
        .rd_addr (cmd_addr),
        .rd_data (rd_vol)
    );

    whr_ram #(
        .WIDTH (whr_pkg::SUM_W),
        .DEPTH (DEPTH)
    ) u_mass_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_mass),
        .rd_en   (q_pop),
        .rd_addr (cmd_addr),
        .rd_data (rd_mass)
    );

    // Sequencer with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
            op_reg      <= whr_pkg::OP_ACCUM;
            addr_reg    <= '0;
            bin_reg     <= '0;
            vol_reg     <= '0;
            mass_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_bin_reg   <= '0;
            m_vol_reg   <= '0;
            m_mass_reg  <= '0;
            m_sat_reg   <= 1'b0;
        end
        else
        begin
            // Result taken and no new one loaded this cycle
            if (m_valid_reg && m_ready && !upd_done)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        op_reg    <= cmd_op;
                        addr_reg  <= cmd_addr;
                        bin_reg   <= q_data[BIN_LO +: whr_pkg::BIN_OUT_W];
                        vol_reg   <= q_data[VOL_LO +: whr_pkg::VOL_W];
                        mass_reg  <= q_data[whr_pkg::MASS_W-1:0];
                        state_reg <= B_UPD;
                    end
                end
                B_UPD:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_bin_reg   <= bin_reg;
                        m_vol_reg   <= res_vol;
                        m_mass_reg  <= res_mass;
                        m_sat_reg   <= (res_vol == whr_pkg::SUM_MAX) ||
                                       (res_mass == whr_pkg::SUM_MAX);
                        state_reg   <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_bin      = m_bin_reg;
    assign m_vol_sum  = m_vol_reg;
    assign m_mass_sum = m_mass_reg;
    assign m_sat      = m_sat_reg;

    // Sums only grow on an update
    a_sums_grow: assert property (@(posedge clk) disable iff (!rst_n)
        upd_done |-> (res_vol >= rd_vol) && (res_mass >= rd_mass))
        else $error("histogram sum decreased");
    // Nothing comes out before the tables are cleared
    a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !m_valid_reg && !q_pop)
        else $error("result or pop during clearing pass");

endmodule

`default_nettype wire

[rtl/weighted_temperature_histogram.sv]
// Weighted temperature histogram over NUM_SLOTS time slots of NUM_BINS bins. After reset
// the block clears both tables, one entry per cycle, with s_tready low; configuration
// writes are taken meanwhile. An accumulate request passes through the front's work and
// push states, its work state set by the restoring bin divider that yields one quotient
// bit per cycle; a read request goes straight to the push state. The back serves one
// request at a time: a table read on the pop, then the table write for an accumulate and
// the result load, which wait for the result port to be free. A four-entry queue lets
// the front keep taking requests while the back or the result port stalls.
`default_nettype none

module weighted_temperature_histogram #(
    parameter int NUM_BINS  = whr_pkg::DEF_NUM_BINS,
    parameter int NUM_SLOTS = whr_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration: index 0 temp_minimum, index 1 bin_width
    input  wire logic                             cfg_we,
    input  wire logic [whr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [whr_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // slot, temperature, cell_volume, density, mass_fraction, read_bin, zero pad
    input  wire logic [whr_pkg::S_TDATA_W-1:0]    s_tdata,
    // op
    input  wire logic                             s_tuser,
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // bin_index, volume_sum, mass_sum, zero pad
    output logic      [whr_pkg::M_TDATA_W-1:0]    m_tdata,
    // saturated
    output logic                                  m_tuser
);

    localparam int ADDR_W = $clog2(NUM_SLOTS * NUM_BINS);
    localparam int CMD_W  = 1 + ADDR_W + whr_pkg::BIN_OUT_W + whr_pkg::VOL_W + whr_pkg::MASS_W;

    localparam int TEMP_LO = whr_pkg::SLOT_IN_W;
    localparam int VOL_LO  = TEMP_LO + whr_pkg::TEMP_W;
    localparam int DENS_LO = VOL_LO + whr_pkg::VOL_W;
    localparam int FRAC_LO = DENS_LO + whr_pkg::DENS_W;
    localparam int RBIN_LO = FRAC_LO + whr_pkg::FRAC_W;
    localparam int M_PAD   = whr_pkg::M_TDATA_W - whr_pkg::BIN_OUT_W - 2 * whr_pkg::SUM_W;

    logic                          clearing;
    logic                          q_push;
    logic                          q_pop;
    logic                          q_full;
    logic                          q_empty;
    logic [CMD_W-1:0]              q_in;
    logic [CMD_W-1:0]              q_out;
    logic [whr_pkg::BIN_OUT_W-1:0] res_bin;
    logic [whr_pkg::SUM_W-1:0]     res_vol;
    logic [whr_pkg::SUM_W-1:0]     res_mass;

    whr_front #(
        .NUM_BINS  (NUM_BINS),
        .NUM_SLOTS (NUM_SLOTS),
        .CMD_W     (CMD_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (whr_pkg::op_t'(s_tuser)),
        .in_slot   (s_tdata[whr_pkg::SLOT_IN_W-1:0]),
        .in_temp   (s_tdata[TEMP_LO +: whr_pkg::TEMP_W]),
        .in_vol    (s_tdata[VOL_LO +: whr_pkg::VOL_W]),
        .in_dens   (s_tdata[DENS_LO +: whr_pkg::DENS_W]),
        .in_frac   (s_tdata[FRAC_LO +: whr_pkg::FRAC_W]),
        .in_rbin   (s_tdata[RBIN_LO +: whr_pkg::RBIN_W]),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    whr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (whr_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    whr_back #(
        .NUM_BINS  (NUM_BINS),
        .NUM_SLOTS (NUM_SLOTS),
        .CMD_W     (CMD_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_bin      (res_bin),
        .m_vol_sum  (res_vol),
        .m_mass_sum (res_mass),
        .m_sat      (m_tuser)
    );

    // Result packing, first field in the low bits
    assign m_tdata = {{M_PAD{1'b0}}, res_mass, res_vol, res_bin};

endmodule

`default_nettype wire
